// ===== hdl/utf8_codepoint_decoder_unit_macros.svh =====
// assertion macros for the utf8 code point decoder checker
// no dependencies; included by the checker file
`ifndef UTF8_CODEPOINT_DECODER_UNIT_MACROS_SVH
`define UTF8_CODEPOINT_DECODER_UNIT_MACROS_SVH

// implication checked outside reset
`define UTF8D_ASSERT_RUN(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// implication checked on every edge, reset included
`define UTF8D_ASSERT_ALL(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/utf8d_pkg.sv =====
// shared types, constants and the offset table of the utf8 decoder
// no dependencies
package utf8d_pkg;

  localparam int CP_W  = 32;
  localparam int CNT_W = 3;

  localparam logic [1:0]       CONT_TAG = 2'b10;
  localparam logic [CNT_W-1:0] SEQ_MAX  = 3'd6;
  localparam logic [CNT_W-1:0] CNT_ONE  = 3'd1;
  localparam logic [CNT_W-1:0] CNT_IDLE = 3'd0;

  // one pending code point, before the offset is taken off
  typedef struct packed {
    logic [CP_W-1:0]  acc;
    logic [CNT_W-1:0] cnt;
    logic             tl;
  } res_t;

  // results caused by one accepted byte: a = flushed by a start byte, b = end of text
  typedef struct packed {
    logic a_vld;
    res_t a;
    logic b_vld;
    res_t b;
  } entry_t;

  // queue status seen by the back end
  typedef struct packed {
    logic   vld;
    entry_t head;
  } q_head_t;

  function automatic logic [CP_W-1:0] seq_offset(input logic [CNT_W-1:0] cnt);
    logic [CP_W-1:0] off;
    unique case (cnt)
      3'd0, 3'd1: off = 32'h0000_0000;
      3'd2:       off = 32'h0000_3080;
      3'd3:       off = 32'h000E_2080;
      3'd4:       off = 32'h03C8_2080;
      3'd5:       off = 32'hFA08_2080;
      default:    off = 32'h8208_2080;
    endcase
    return off;
  endfunction

endpackage

// ===== hdl/utf8d_if.sv =====
// byte and code point channel interfaces of the utf8 decoder
// depends on nothing
interface utf8d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;
  modport source (output valid, data_byte, end_of_text, input ready);
  modport sink   (input valid, data_byte, end_of_text, output ready);
endinterface

interface utf8d_cp_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_point;
  logic        too_long;
  logic        last_result;
  modport source (output valid, code_point, too_long, last_result, input ready);
  modport sink   (input valid, code_point, too_long, last_result, output ready);
endinterface

// ===== hdl/utf8d_front.sv =====
// front end: accepts bytes, tracks the pending sequence, builds result entries
// depends on utf8d_pkg and utf8d_byte_if
module utf8d_front (
  input  logic                 clk,
  input  logic                 rst_n,
  utf8d_byte_if.sink           in_ch,
  input  logic                 q_full,
  output logic                 push,
  output utf8d_pkg::entry_t    push_ent
);

  logic [utf8d_pkg::CP_W-1:0]  acc_r, acc_nxt, acc_mid;
  logic [utf8d_pkg::CNT_W-1:0] cnt_r, cnt_nxt, cnt_mid;
  logic                        ovf_r, ovf_nxt, ovf_mid;
  logic                        cont, accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign cont        = in_ch.data_byte[7:6] == utf8d_pkg::CONT_TAG;

  always_comb begin
    push_ent       = '0;
    push_ent.a.acc = acc_r;
    push_ent.a.cnt = cnt_r;
    push_ent.a.tl  = ovf_r;
    acc_mid        = {24'd0, in_ch.data_byte};
    cnt_mid        = utf8d_pkg::CNT_ONE;
    ovf_mid        = 1'b0;
    if (cnt_r == utf8d_pkg::CNT_IDLE) begin
      // first byte after idle always opens a sequence
    end else if (cont) begin
      acc_mid = {acc_r[utf8d_pkg::CP_W-7:0], 6'd0} + {24'd0, in_ch.data_byte};
      if (cnt_r < utf8d_pkg::SEQ_MAX) begin
        cnt_mid = cnt_r + utf8d_pkg::CNT_ONE;
        ovf_mid = ovf_r;
      end else begin
        cnt_mid = cnt_r;
        ovf_mid = 1'b1;
      end
    end else begin
      push_ent.a_vld = 1'b1;
    end
    push_ent.b_vld = in_ch.end_of_text;
    push_ent.b.acc = acc_mid;
    push_ent.b.cnt = cnt_mid;
    push_ent.b.tl  = ovf_mid;
    if (in_ch.end_of_text) begin
      acc_nxt = '0;
      cnt_nxt = utf8d_pkg::CNT_IDLE;
      ovf_nxt = 1'b0;
    end else begin
      acc_nxt = acc_mid;
      cnt_nxt = cnt_mid;
      ovf_nxt = ovf_mid;
    end
  end

  assign push = accept && (push_ent.a_vld || push_ent.b_vld);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= utf8d_pkg::CNT_IDLE;
      ovf_r <= 1'b0;
    end else if (accept) begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

endmodule

// ===== hdl/utf8d_queue.sv =====
// two-entry queue between front and back end
// depends on utf8d_pkg
module utf8d_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  utf8d_pkg::entry_t    push_ent,
  input  logic                 pop,
  output logic                 full,
  output utf8d_pkg::q_head_t   head
);

  utf8d_pkg::entry_t ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full      = cnt_r == 2'd2;
  assign head.vld  = cnt_r != 2'd0;
  assign head.head = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== hdl/utf8d_back.sv =====
// back end: walks the results of each entry, takes the offset off, output register
// depends on utf8d_pkg and utf8d_cp_if
module utf8d_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utf8d_pkg::q_head_t   head,
  output logic                 pop,
  utf8d_cp_if.source           out_ch
);

  logic                       vld_r;
  logic                       phase_r, phase_nxt;
  logic [utf8d_pkg::CP_W-1:0] cp_r, cp_nxt;
  logic                       tl_r, last_r, last_nxt;
  logic                       load, use_b;
  utf8d_pkg::res_t            sel;

  assign load     = head.vld && (!vld_r || out_ch.ready);
  assign use_b    = phase_r || !head.head.a_vld;
  assign sel      = use_b ? head.head.b : head.head.a;
  assign last_nxt = use_b || !head.head.b_vld;
  assign pop      = load && last_nxt;
  assign cp_nxt   = sel.acc - utf8d_pkg::seq_offset(sel.cnt);

  always_comb begin
    phase_nxt = phase_r;
    if (load) begin
      phase_nxt = !last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (load) begin
        vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cp_r   <= cp_nxt;
      tl_r   <= sel.tl;
      last_r <= last_nxt;
    end
  end

  assign out_ch.valid       = vld_r;
  assign out_ch.code_point  = cp_r;
  assign out_ch.too_long    = tl_r;
  assign out_ch.last_result = last_r;

endmodule

// ===== hdl/utf8_codepoint_decoder_unit.sv =====
// top level of the streaming utf8 code point decoder
// depends on utf8d_pkg, utf8d_if, utf8d_front, utf8d_queue and utf8d_back
//
// usage:
//   in_ch takes one byte of the string per request, with end_of_text on the
//   last byte. out_ch gives decoded code points, each with too_long (more
//   than six bytes in the sequence) and last_result (final result of a byte).
//   a start byte flushes the pending sequence; end_of_text flushes the
//   sequence holding that byte, so one byte can give zero, one or two results.
// timing:
//   a result passes through the queue and the output register before it shows
//   on out_ch. bytes are taken one per cycle while the queue is not full;
//   results leave one per cycle while out_ch is ready.
// reset:
//   rst_n low clears the pending sequence, the queue and the output register.
// stall:
//   while out_ch is stalled the output register holds; the two-entry queue
//   keeps absorbing bytes, and in_ch.ready drops only when the queue is full.
module utf8_codepoint_decoder_unit (
  input  logic         clk,
  input  logic         rst_n,
  utf8d_byte_if.sink   in_ch,
  utf8d_cp_if.source   out_ch
);

  // front to queue
  logic              push;
  utf8d_pkg::entry_t push_ent;
  // queue status
  logic               q_full;
  utf8d_pkg::q_head_t q_head;
  // back to queue
  logic               pop;

  // byte intake, sequence tracking and result classification
  utf8d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_ent (push_ent)
  );

  // decouples intake from output stalls
  utf8d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_ent (push_ent),
    .pop      (pop),
    .full     (q_full),
    .head     (q_head)
  );

  // offset subtraction and output register
  utf8d_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== hdl/utf8d_checker.sv =====
// port-level checker of the utf8 decoder, bound to the top level
// depends on utf8_codepoint_decoder_unit_macros.svh
`include "utf8_codepoint_decoder_unit_macros.svh"

module utf8d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] code_point,
  input logic        too_long,
  input logic        last_result
);

  // stalled result holds
  `UTF8D_ASSERT_RUN(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(too_long) && $stable(last_result), "stalled result changed")
  // second result of a byte follows right after the first
  `UTF8D_ASSERT_RUN(a_second_follows, clk, rst_n, out_valid && out_ready && !last_result |=> out_valid, "second result of a byte missing")
  // a full queue implies the output register is loaded
  `UTF8D_ASSERT_RUN(a_full_has_out, clk, rst_n, !in_ready |-> out_valid, "intake blocked with empty output")
  // reset empties the output
  `UTF8D_ASSERT_ALL(a_reset_clears, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind utf8_codepoint_decoder_unit utf8d_checker u_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .code_point  (out_ch.code_point),
  .too_long    (out_ch.too_long),
  .last_result (out_ch.last_result)
);

// ===== bench/tb_top.sv =====
// self-checking bench for utf8_codepoint_decoder_unit: byte requests in, code points out
// depends on utf8d_pkg and the utf8d_byte_if / utf8d_cp_if interfaces of the rtl
`timescale 1ns / 100ps

module tb_top;

  // one byte request waiting to be driven, with the idling of its phase
  typedef struct packed {
    logic [7:0] data;
    logic       eot;
    logic       drain_first;
    logic [6:0] tx_pct;
    logic [6:0] rx_pct;
  } byte_req_t;

  // one expected code point result
  typedef struct packed {
    logic [utf8d_pkg::CP_W-1:0] code_point;
    logic                       too_long;
    logic                       last_result;
  } cp_rec_t;

  localparam int PHASE_ITEMS = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic clk;
  logic rst_n;

  utf8d_byte_if in_bus();
  utf8d_cp_if   out_bus();

  utf8_codepoint_decoder_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus.sink),
    .out_ch (out_bus.source)
  );

  byte_req_t pending_bytes[$];
  cp_rec_t   expected_cps[$];

  // decoder state as the bench sees it
  logic [utf8d_pkg::CP_W-1:0]  acc_q;
  logic [utf8d_pkg::CNT_W-1:0] seq_len_q;
  logic                        ovf_q;

  logic       in_taken;
  logic [6:0] rx_pct;
  int         total_bytes;
  int         sent_cnt;
  int         checked_cnt;
  int         overlong_cnt;
  int         dual_cnt;
  int         err_cnt;
  int         cycle_cnt;

  // clock, 12 ns period
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // amount taken off the accumulator for a sequence of n bytes
  function automatic logic [utf8d_pkg::CP_W-1:0] span_offset(
      input logic [utf8d_pkg::CNT_W-1:0] n);
    logic [utf8d_pkg::CP_W-1:0] off;
    case (n)
      3'd2:    off = 32'h0000_3080;
      3'd3:    off = 32'h000E_2080;
      3'd4:    off = 32'h03C8_2080;
      3'd5:    off = 32'hFA08_2080;
      3'd6:    off = 32'h8208_2080;
      default: off = 32'h0000_0000;
    endcase
    return off;
  endfunction

  function automatic void queue_byte(input logic [7:0] b, input logic eot,
                                     input logic [6:0] tx, input logic [6:0] rx);
    byte_req_t r;
    r.data        = b;
    r.eot         = eot;
    r.drain_first = 1'b0;
    r.tx_pct      = tx;
    r.rx_pct      = rx;
    pending_bytes.push_back(r);
  endfunction

  // one random group of bytes; returns how many bytes were queued
  function automatic int queue_random(input logic [6:0] tx, input logic [6:0] rx);
    int         kind;
    int         len;
    int         i;
    logic [7:0] lead;
    logic       eot;
    kind = $urandom_range(99);
    eot  = ($urandom_range(7) == 0);
    if (kind >= 90) begin
      // noise: any byte, any end flag
      queue_byte(8'($urandom_range(255)), ($urandom_range(9) == 0), tx, rx);
      return 1;
    end
    if (kind < 83) begin
      len = $urandom_range(1, 6);
      case (len)
        1:       lead = 8'($urandom_range(0, 127));
        2:       lead = 8'($urandom_range(192, 223));
        3:       lead = 8'($urandom_range(224, 239));
        4:       lead = 8'($urandom_range(240, 247));
        5:       lead = 8'($urandom_range(248, 251));
        default: lead = 8'($urandom_range(252, 253));
      endcase
      // truncated sequence: lead promises more bytes than follow
      if (kind >= 75 && len > 1) len = $urandom_range(1, len - 1);
    end else begin
      // overlong run of continuations
      lead = 8'($urandom_range(192, 255));
      len  = $urandom_range(7, 10);
    end
    for (i = 0; i < len; i++) begin
      if (i == 0) queue_byte(lead, eot && (len == 1), tx, rx);
      else queue_byte(8'h80 | 8'($urandom_range(63)), eot && (i == len - 1), tx, rx);
    end
    return len;
  endfunction

  // predictor: absorb one accepted byte and queue the results it causes
  task automatic decode_byte(input logic [7:0] b, input logic eot);
    cp_rec_t flushed;
    cp_rec_t closing;
    logic    have_flush;
    have_flush = 1'b0;
    if (seq_len_q == utf8d_pkg::CNT_IDLE) begin
      // idle: every byte starts a sequence, continuation or not
      acc_q     = {24'd0, b};
      seq_len_q = utf8d_pkg::CNT_ONE;
      ovf_q     = 1'b0;
    end else if (b[7:6] == utf8d_pkg::CONT_TAG) begin
      acc_q = (acc_q << 6) + {24'd0, b};
      if (seq_len_q < utf8d_pkg::SEQ_MAX) seq_len_q = seq_len_q + 3'd1;
      else begin
        if (!ovf_q) overlong_cnt++;
        ovf_q = 1'b1;
      end
    end else begin
      // start byte while pending: flush, then begin again
      flushed.code_point  = acc_q - span_offset(seq_len_q);
      flushed.too_long    = ovf_q;
      flushed.last_result = 1'b1;
      have_flush          = 1'b1;
      acc_q               = {24'd0, b};
      seq_len_q           = utf8d_pkg::CNT_ONE;
      ovf_q               = 1'b0;
    end
    if (eot) begin
      closing.code_point  = acc_q - span_offset(seq_len_q);
      closing.too_long    = ovf_q;
      closing.last_result = 1'b1;
      if (have_flush) begin
        flushed.last_result = 1'b0;
        expected_cps.push_back(flushed);
        dual_cnt++;
      end
      expected_cps.push_back(closing);
      acc_q     = '0;
      seq_len_q = utf8d_pkg::CNT_IDLE;
      ovf_q     = 1'b0;
    end else if (have_flush) begin
      expected_cps.push_back(flushed);
    end
  endtask

  // sampling at the rising edge: check results first, then predict the accepted byte
  always @(posedge clk) begin : sample_side
    cp_rec_t want;
    in_taken <= in_bus.valid && in_bus.ready && rst_n;
    if (!rst_n) begin
      acc_q     = '0;
      seq_len_q = utf8d_pkg::CNT_IDLE;
      ovf_q     = 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_cps.size() == 0) begin
          $error("unexpected code point %h", out_bus.code_point);
          err_cnt++;
        end else begin
          want = expected_cps.pop_front();
          checked_cnt++;
          if (out_bus.code_point !== want.code_point) begin
            $error("code_point: expected %h, actual %h", want.code_point, out_bus.code_point);
            err_cnt++;
          end
          if (out_bus.too_long !== want.too_long) begin
            $error("too_long: expected %b, actual %b", want.too_long, out_bus.too_long);
            err_cnt++;
          end
          if (out_bus.last_result !== want.last_result) begin
            $error("last_result: expected %b, actual %b",
                   want.last_result, out_bus.last_result);
            err_cnt++;
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        sent_cnt++;
        decode_byte(in_bus.data_byte, in_bus.end_of_text);
      end
    end
  end

  // driving at the falling edge: byte requests and result ready
  always @(negedge clk) begin : drive_side
    byte_req_t nxt;
    if (!rst_n) begin
      rx_pct = 7'd0;
      in_bus.valid       <= 1'b0;
      in_bus.data_byte   <= 8'h00;
      in_bus.end_of_text <= 1'b0;
      out_bus.ready      <= 1'b0;
    end else begin
      if (in_bus.valid && !in_taken) begin
        // request still waiting for ready: hold it
      end else if (pending_bytes.size() > 0
                   && !(pending_bytes[0].drain_first && expected_cps.size() != 0)
                   && $urandom_range(99) >= pending_bytes[0].tx_pct) begin
        nxt = pending_bytes.pop_front();
        rx_pct = nxt.rx_pct;
        in_bus.valid       <= 1'b1;
        in_bus.data_byte   <= nxt.data;
        in_bus.end_of_text <= nxt.eot;
      end else begin
        in_bus.valid <= 1'b0;
      end
      // receiver stalls follow the phase of the last byte launched
      out_bus.ready <= ($urandom_range(99) >= rx_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    logic [6:0] tx_tab[4];
    logic [6:0] rx_tab[4];
    int         p;
    int         n;
    int         first;
    int         i;
    tx_tab = '{7'd0, 7'd61, 7'd0, 7'd23};
    rx_tab = '{7'd0, 7'd0, 7'd61, 7'd23};

    rst_n = 1'b0;

    // directed: continuation straight after reset, zero byte, 2/3/6-byte sequences
    queue_byte(8'h80, 1'b0, 7'd0, 7'd0);
    queue_byte(8'h00, 1'b0, 7'd0, 7'd0);
    queue_byte(8'hC3, 1'b0, 7'd0, 7'd0);
    queue_byte(8'hA9, 1'b0, 7'd0, 7'd0);
    queue_byte(8'hE2, 1'b0, 7'd0, 7'd0);
    queue_byte(8'h82, 1'b0, 7'd0, 7'd0);
    queue_byte(8'hAC, 1'b0, 7'd0, 7'd0);
    queue_byte(8'hFC, 1'b0, 7'd0, 7'd0);
    for (i = 0; i < 4; i++) queue_byte(8'h80, 1'b0, 7'd0, 7'd0);
    queue_byte(8'hBF, 1'b0, 7'd0, 7'd0);
    // overlong: 0xff plus six continuations, end of text on the last one
    queue_byte(8'hFF, 1'b0, 7'd0, 7'd0);
    for (i = 0; i < 5; i++) queue_byte(8'hBF, 1'b0, 7'd0, 7'd0);
    queue_byte(8'hBF, 1'b1, 7'd0, 7'd0);
    // idle start, then start byte with end of text: two results from one request
    queue_byte(8'h7F, 1'b0, 7'd0, 7'd0);
    queue_byte(8'hF0, 1'b1, 7'd0, 7'd0);
    // lone continuation with end of text from idle
    queue_byte(8'hBF, 1'b1, 7'd0, 7'd0);

    // random phases; each later phase opens by waiting for the results to drain
    for (p = 0; p < 4; p++) begin
      first = pending_bytes.size();
      n = 0;
      while (n < PHASE_ITEMS) n += queue_random(tx_tab[p], rx_tab[p]);
      if (p > 0) pending_bytes[first].drain_first = 1'b1;
    end
    total_bytes = pending_bytes.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // every request taken and every result seen, then a short tail
    while (sent_cnt != total_bytes || expected_cps.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);

    $display("tb_top: %0d byte requests, %0d code points compared", sent_cnt, checked_cnt);
    $display("tb_top: %0d overlong sequences, %0d requests with two results",
             overlong_cnt, dual_cnt);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

// ===== utf8_codepoint_decoder_unit.f =====
+incdir+hdl
hdl/utf8d_pkg.sv
hdl/utf8d_if.sv
hdl/utf8d_front.sv
hdl/utf8d_queue.sv
hdl/utf8d_back.sv
hdl/utf8_codepoint_decoder_unit.sv
hdl/utf8d_checker.sv
bench/tb_top.sv
